// File: rtl/dfrq_pkg.sv
// Shared types and constants for the direction filtered request queue.
package dfrq_pkg;

    localparam int DEPTH     = 16;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int TAG_W     = 16;
    localparam int DATA_W    = 32;
    localparam int AHEAD_W   = 5;

    typedef enum logic [1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_CANCEL = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic              up;
        logic [DATA_W-1:0] data;
    } entry_t;

    typedef struct packed {
        logic             en;
        kind_t            kind;
        logic [TAG_W-1:0] tag;
        logic             serve_up;
        logic             serve_down;
    } cell_ctrl_t;

endpackage

// File: rtl/dfrq_cell.sv
// One queue slot: match test, first-match chain link and shift/load logic.
module dfrq_cell
    import dfrq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       valid,
    input  logic       prev_valid,
    input  logic       before_in,
    input  entry_t     neighbor,
    input  entry_t     push_entry,
    output logic       before_out,
    output logic       sel,
    output entry_t     entry_q
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   hit;

    always_comb
    begin
        hit = 1'b0;
        case (ctrl.kind)
            KIND_POP:
            begin
                hit = valid & ((entry_reg.up & ctrl.serve_up) |
                               (~entry_reg.up & ctrl.serve_down));
            end
            KIND_CANCEL, KIND_QUERY:
            begin
                hit = valid & (entry_reg.tag == ctrl.tag);
            end
            default:
            begin
                hit = 1'b0;
            end
        endcase
    end

    assign before_out = before_in | hit;
    assign sel        = hit & ~before_in;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.en)
        begin
            case (ctrl.kind)
                KIND_PUSH:
                begin
                    // first free slot takes the new beat
                    if (~valid & prev_valid)
                    begin
                        entry_next = push_entry;
                    end
                end
                KIND_POP, KIND_CANCEL:
                begin
                    // at and after the removed slot, pull from the younger neighbor
                    if (before_out)
                    begin
                        entry_next = neighbor;
                    end
                end
                default:
                begin
                    entry_next = entry_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;

endmodule

// File: rtl/direction_filtered_request_queue_top.sv
// Top level of the direction filtered request queue: request stage, cell row, result stage.
//
// Usage:
//  - Input channel (in_valid / in_stall): one beat carries one request; kind picks
//    push, filtered pop, cancel by tag or position query.
//  - Output channel (out_valid / out_stall): exactly one result beat per request,
//    in request order.
//  - An accepted request waits in the request register and moves into the result
//    register once the output is free. The request register and the result register
//    overlap, so a new request is taken every cycle as long as the receiver keeps up.
//  - The queue is a row of DEPTH cells. All cells compare against the request in
//    parallel; a first-match chain runs through the row, and every cell at or past
//    the removed slot loads its younger neighbor in the same cycle.
//  - The none_up / none_down flags are computed from the post-update contents.
//  - Reset empties the queue (fill count to zero) and drops any pending request
//    or result; cell contents are not cleared and are never read while invalid.
//  - When the receiver stalls, the result beat is held; the pending request waits
//    in its register and the input stalls until the result register frees up.
module direction_filtered_request_queue_top
    import dfrq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        kind,
    input  logic [TAG_W-1:0]  tag,
    input  logic              goes_up,
    input  logic [DATA_W-1:0] payload,
    input  logic              serve_up,
    input  logic              serve_down,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              ok,
    output logic [TAG_W-1:0]  out_tag,
    output logic              out_up,
    output logic [DATA_W-1:0] out_payload,
    output logic [AHEAD_W-1:0] ahead,
    output logic              none_up,
    output logic              none_down
);

    // request stage
    logic              req_valid_reg;
    logic              req_valid_next;
    kind_t             req_kind_reg;
    logic [TAG_W-1:0]  req_tag_reg;
    logic              req_up_reg;
    logic [DATA_W-1:0] req_payload_reg;
    logic              req_su_reg;
    logic              req_sd_reg;

    // fill count
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    // result stage
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              ok_reg;
    logic              ok_next;
    entry_t            pop_reg;
    entry_t            pop_next;
    logic [AHEAD_W-1:0] ahead_reg;
    logic [AHEAD_W-1:0] ahead_next;
    logic              none_up_reg;
    logic              none_up_next;
    logic              none_down_reg;
    logic              none_down_next;

    logic              fire;
    logic              accept;
    logic              full;
    logic              found;
    cell_ctrl_t        ctrl;
    entry_t            push_entry;
    entry_t            pop_entry;
    logic [CNT_W-1:0]  pos;

    logic [DEPTH-1:0]  valid_vec;
    logic [DEPTH-1:0]  valid_next_vec;
    logic [DEPTH-1:0]  sel_vec;
    logic [DEPTH:0]    before_vec;
    entry_t            entry_q [DEPTH];

    // a pending request executes once the result register can take its beat
    assign fire     = req_valid_reg & (~out_valid_reg | ~out_stall);
    assign in_stall = req_valid_reg & ~fire;
    assign accept   = in_valid & ~in_stall;

    assign full  = (cnt_reg == CNT_W'(DEPTH));
    assign found = before_vec[DEPTH];

    assign ctrl.en         = fire;
    assign ctrl.kind       = req_kind_reg;
    assign ctrl.tag        = req_tag_reg;
    assign ctrl.serve_up   = req_su_reg;
    assign ctrl.serve_down = req_sd_reg;

    assign push_entry.tag  = req_tag_reg;
    assign push_entry.up   = req_up_reg;
    assign push_entry.data = req_payload_reg;

    assign before_vec[0] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            entry_t nb;
            logic   pv;

            assign valid_vec[gi] = (cnt_reg > CNT_W'(gi));

            if (gi == 0)
            begin : g_head
                assign pv = 1'b1;
            end
            else
            begin : g_body
                assign pv = valid_vec[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign nb = '0;
            end
            else
            begin : g_mid
                assign nb = entry_q[gi+1];
            end

            dfrq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .valid      (valid_vec[gi]),
                .prev_valid (pv),
                .before_in  (before_vec[gi]),
                .neighbor   (nb),
                .push_entry (push_entry),
                .before_out (before_vec[gi+1]),
                .sel        (sel_vec[gi]),
                .entry_q    (entry_q[gi])
            );
        end
    endgenerate

    // one-hot select of the first matching slot
    always_comb
    begin
        pop_entry = '0;
        pos       = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (sel_vec[i])
            begin
                pop_entry = pop_entry | entry_q[i];
                pos       = pos | CNT_W'(i);
            end
        end
        if (!found)
        begin
            pos = cnt_reg;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        ok_next  = 1'b0;
        pop_next = '0;
        ahead_next = '0;
        case (req_kind_reg)
            KIND_PUSH:
            begin
                ok_next = ~full;
                if (fire && !full)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            KIND_POP:
            begin
                ok_next = found;
                if (found)
                begin
                    pop_next = pop_entry;
                end
                if (fire && found)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            KIND_CANCEL:
            begin
                ok_next = found;
                if (fire && found)
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            KIND_QUERY:
            begin
                ok_next    = found;
                ahead_next = AHEAD_W'(pos);
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // direction flags from the post-update contents
    always_comb
    begin
        none_up_next   = 1'b1;
        none_down_next = 1'b1;
        for (int i = 0; i < DEPTH; i++)
        begin
            valid_next_vec[i] = (cnt_next > CNT_W'(i));
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            if (valid_next_vec[i])
            begin
                if (i == DEPTH - 1)
                begin
                    if (req_kind_reg == KIND_PUSH && !valid_vec[i])
                    begin
                        none_up_next   = none_up_next & ~req_up_reg;
                        none_down_next = none_down_next & req_up_reg;
                    end
                    else
                    begin
                        none_up_next   = none_up_next & ~entry_q[i].up;
                        none_down_next = none_down_next & entry_q[i].up;
                    end
                end
                else if (req_kind_reg == KIND_PUSH && !valid_vec[i])
                begin
                    none_up_next   = none_up_next & ~req_up_reg;
                    none_down_next = none_down_next & req_up_reg;
                end
                else if ((req_kind_reg == KIND_POP || req_kind_reg == KIND_CANCEL)
                         && before_vec[i+1])
                begin
                    none_up_next   = none_up_next & ~entry_q[i+1].up;
                    none_down_next = none_down_next & entry_q[i+1].up;
                end
                else
                begin
                    none_up_next   = none_up_next & ~entry_q[i].up;
                    none_down_next = none_down_next & entry_q[i].up;
                end
            end
        end
    end

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (fire)
        begin
            req_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_kind_reg    <= kind_t'(kind);
            req_tag_reg     <= tag;
            req_up_reg      <= goes_up;
            req_payload_reg <= payload;
            req_su_reg      <= serve_up;
            req_sd_reg      <= serve_down;
        end
        if (fire)
        begin
            ok_reg        <= ok_next;
            pop_reg       <= pop_next;
            ahead_reg     <= ahead_next;
            none_up_reg   <= none_up_next;
            none_down_reg <= none_down_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign out_tag     = pop_reg.tag;
    assign out_up      = pop_reg.up;
    assign out_payload = pop_reg.data;
    assign ahead       = ahead_reg;
    assign none_up     = none_up_reg;
    assign none_down   = none_down_reg;

    // fill count stays within the row
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    // the first-match chain selects at most one slot
    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(sel_vec))
        else $error("more than one slot selected");

    // a successful push grows the queue by exactly one
    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && req_kind_reg == KIND_PUSH && !full) |=>
            (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("push did not grow the queue");

    // nothing executes while the result register holds a stalled beat
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !fire)
        else $error("result overwritten while stalled");

endmodule

// File: tb/direction_filtered_request_queue_top_tb.sv
// Self-checking testbench for the direction filtered request queue: directed table, then random traffic.
`timescale 1ns / 1ps

module direction_filtered_request_queue_top_tb;

    import dfrq_pkg::*;

    // One result beat as it appears on the output ports, in port order.
    typedef struct packed {
        logic               ok;
        logic [TAG_W-1:0]   tag;
        logic               up;
        logic [DATA_W-1:0]  payload;
        logic [AHEAD_W-1:0] ahead;
        logic               none_up;
        logic               none_down;
    } outcome_t;

    // One request beat. A pinned row carries a hand-written expected outcome.
    typedef struct packed {
        kind_t              kind;
        logic [TAG_W-1:0]   tag;
        logic               goes_up;
        logic [DATA_W-1:0]  payload;
        logic               serve_up;
        logic               serve_down;
        logic               pinned;
        outcome_t           want;
    } request_t;

    // Traffic shaping: which side dawdles.
    typedef enum logic [1:0] {
        PACE_RECV_LAGS,
        PACE_SEND_LAGS,
        PACE_OPEN
    } pace_t;

    localparam int RANDOM_ITEMS   = 2000;
    localparam int SQUEEZE_CYCLES = 80;     // long receiver hold-off at the start of PACE_OPEN
    localparam int STUCK_LIMIT    = 2000;   // cycles without any beat before giving up
    localparam int DRAIN_CYCLES   = 8;      // drain time after the last expected beat
    localparam int REPORT_LIMIT   = 10;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         kind;
    logic [TAG_W-1:0]   tag;
    logic               goes_up;
    logic [DATA_W-1:0]  payload;
    logic               serve_up;
    logic               serve_down;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               ok;
    logic [TAG_W-1:0]   out_tag;
    logic               out_up;
    logic [DATA_W-1:0]  out_payload;
    logic [AHEAD_W-1:0] ahead;
    logic               none_up;
    logic               none_down;

    // Request on the input ports; only ever updated with NBAs at posedge.
    request_t cur_req = '0;

    assign kind       = cur_req.kind;
    assign tag        = cur_req.tag;
    assign goes_up    = cur_req.goes_up;
    assign payload    = cur_req.payload;
    assign serve_up   = cur_req.serve_up;
    assign serve_down = cur_req.serve_down;

    direction_filtered_request_queue_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .tag         (tag),
        .goes_up     (goes_up),
        .payload     (payload),
        .serve_up    (serve_up),
        .serve_down  (serve_down),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .out_tag     (out_tag),
        .out_up      (out_up),
        .out_payload (out_payload),
        .ahead       (ahead),
        .none_up     (none_up),
        .none_down   (none_down)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the queue contents, oldest entry first, and the outcomes
    // still owed by the block, in request order.
    // ------------------------------------------------------------------
    entry_t   shadow_entries[$];
    outcome_t due_results[$];

    request_t dir_rows[$];
    int       row_idx = 0;
    int       rand_made = 0;
    logic     stim_done = 1'b0;
    pace_t    pace;

    // Random traffic alternates between bursts that tend to fill the queue
    // and bursts that tend to drain it, so both full and empty get visited.
    logic     fill_bias = 1'b0;
    int       burst_left = 0;

    int       squeeze_left = SQUEEZE_CYCLES;
    int       stuck_cycles = 0;
    int       mismatch_count = 0;
    int       result_count = 0;
    outcome_t got, want;
    string    diff_fields;

    // Apply one request to the shadow queue and return what the block
    // must answer. Removal keeps the order of the remaining entries.
    function automatic outcome_t apply_request(request_t r);
        outcome_t o;
        entry_t   e;
        int       hit;
        o   = '0;
        hit = -1;
        case (r.kind)
            KIND_PUSH:
            begin
                if (shadow_entries.size() < DEPTH)
                begin
                    e.tag  = r.tag;
                    e.up   = r.goes_up;
                    e.data = r.payload;
                    shadow_entries.push_back(e);
                    o.ok = 1'b1;
                end
            end
            KIND_POP:
            begin
                // oldest entry whose direction is enabled
                for (int i = 0; i < shadow_entries.size(); i++)
                begin
                    if (hit < 0 && ((shadow_entries[i].up && r.serve_up) ||
                                    (!shadow_entries[i].up && r.serve_down)))
                        hit = i;
                end
                if (hit >= 0)
                begin
                    o.ok      = 1'b1;
                    o.tag     = shadow_entries[hit].tag;
                    o.up      = shadow_entries[hit].up;
                    o.payload = shadow_entries[hit].data;
                    shadow_entries.delete(hit);
                end
            end
            default:
            begin
                // cancel and query both act on the oldest entry with the tag
                for (int i = 0; i < shadow_entries.size(); i++)
                begin
                    if (hit < 0 && shadow_entries[i].tag == r.tag)
                        hit = i;
                end
                o.ok = (hit >= 0);
                if (r.kind == KIND_CANCEL)
                begin
                    if (hit >= 0)
                        shadow_entries.delete(hit);
                end
                else
                    o.ahead = AHEAD_W'((hit >= 0) ? hit : shadow_entries.size());
            end
        endcase
        o.none_up   = 1'b1;
        o.none_down = 1'b1;
        foreach (shadow_entries[i])
        begin
            if (shadow_entries[i].up)
                o.none_up = 1'b0;
            else
                o.none_down = 1'b0;
        end
        return o;
    endfunction

    // Outcome with no popped entry: only ok, ahead and the two flags set.
    function automatic outcome_t plain(int k, int a, int nu, int nd);
        outcome_t o;
        o           = '0;
        o.ok        = (k != 0);
        o.ahead     = AHEAD_W'(a);
        o.none_up   = (nu != 0);
        o.none_down = (nd != 0);
        return o;
    endfunction

    task automatic add_row(kind_t k, logic [TAG_W-1:0] t, logic u, logic [DATA_W-1:0] p,
                           logic su, logic sd, logic pin, outcome_t w);
        request_t r;
        r.kind       = k;
        r.tag        = t;
        r.goes_up    = u;
        r.payload    = p;
        r.serve_up   = su;
        r.serve_down = sd;
        r.pinned     = pin;
        r.want       = w;
        dir_rows.push_back(r);
    endtask

    task automatic show_mismatch(int n, string fields, outcome_t w, outcome_t g);
        $display("result beat %0d differs in%s", n, fields);
        $display("  expected ok=%b tag=%h up=%b payload=%h ahead=%0d none_up=%b none_down=%b",
                 w.ok, w.tag, w.up, w.payload, w.ahead, w.none_up, w.none_down);
        $display("  got      ok=%b tag=%h up=%b payload=%h ahead=%0d none_up=%b none_down=%b",
                 g.ok, g.tag, g.up, g.payload, g.ahead, g.none_up, g.none_down);
    endtask

    // Mostly well-formed traffic against the live queue contents: cancels
    // and queries usually name a tag that is present, pushes reuse a small
    // tag pool so duplicates are common. A few beats are pure noise.
    function automatic request_t make_random_request();
        request_t r;
        int       roll;
        r = '0;
        if (burst_left == 0)
        begin
            fill_bias  = !fill_bias;
            burst_left = $urandom_range(60, 20);
        end
        burst_left--;
        r.goes_up    = 1'($urandom);
        r.payload    = $urandom;
        r.serve_up   = 1'($urandom);
        r.serve_down = 1'($urandom);
        roll = $urandom_range(99, 0);
        if (roll < 8)
        begin
            r.kind = kind_t'($urandom_range(3, 0));
            r.tag  = TAG_W'($urandom);
            return r;
        end
        roll = $urandom_range(99, 0);
        if (fill_bias)
            r.kind = (roll < 60) ? KIND_PUSH : (roll < 75) ? KIND_POP :
                     (roll < 85) ? KIND_CANCEL : KIND_QUERY;
        else
            r.kind = (roll < 20) ? KIND_PUSH : (roll < 65) ? KIND_POP :
                     (roll < 85) ? KIND_CANCEL : KIND_QUERY;
        roll = $urandom_range(99, 0);
        if (r.kind != KIND_PUSH && shadow_entries.size() != 0 && roll < 65)
            r.tag = shadow_entries[$urandom_range(shadow_entries.size() - 1, 0)].tag;
        else if (roll < 80)
            r.tag = TAG_W'($urandom_range(23, 0));
        else if (roll < 88)
            r.tag = roll[0] ? '1 : '0;
        else
            r.tag = TAG_W'($urandom);
        return r;
    endfunction

    // Three traffic phases over the random part; the directed table runs
    // in the first one.
    always_comb
    begin
        if (rand_made < RANDOM_ITEMS / 3)
            pace = PACE_RECV_LAGS;
        else if (rand_made < 2 * RANDOM_ITEMS / 3)
            pace = PACE_SEND_LAGS;
        else
            pace = PACE_OPEN;
    end

    // ------------------------------------------------------------------
    // Input side, prediction and checking. Handshake signals are sampled
    // at the edge (pre-NBA values), so beats are seen exactly once.
    // The input beat is predicted before the output beat is checked; with the
    // request and result registers between them they never belong to the same request.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                want = apply_request(cur_req);
                // pinned rows check the hand-written value instead
                due_results.push_back(cur_req.pinned ? cur_req.want : want);
            end

            if (out_valid && !out_stall)
            begin
                result_count++;
                got = {ok, out_tag, out_up, out_payload, ahead, none_up, none_down};
                if (due_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("result beat %0d with nothing expected: ok=%b tag=%h ahead=%0d",
                                 result_count, ok, out_tag, ahead);
                end
                else
                begin
                    want = due_results.pop_front();
                    diff_fields = "";
                    if (got.ok !== want.ok)               diff_fields = {diff_fields, " ok"};
                    if (got.tag !== want.tag)             diff_fields = {diff_fields, " out_tag"};
                    if (got.up !== want.up)               diff_fields = {diff_fields, " out_up"};
                    if (got.payload !== want.payload)     diff_fields = {diff_fields, " out_payload"};
                    if (got.ahead !== want.ahead)         diff_fields = {diff_fields, " ahead"};
                    if (got.none_up !== want.none_up)     diff_fields = {diff_fields, " none_up"};
                    if (got.none_down !== want.none_down) diff_fields = {diff_fields, " none_down"};
                    if (diff_fields != "")
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            show_mismatch(result_count, diff_fields, want, got);
                    end
                end
            end

            // Offer the next beat only once the current one is gone; a held
            // beat keeps valid and payload untouched.
            if (!in_valid || !in_stall)
            begin
                if (row_idx == dir_rows.size() && rand_made == RANDOM_ITEMS)
                begin
                    in_valid  <= 1'b0;
                    stim_done <= 1'b1;
                end
                else if ($urandom_range(99, 0) <
                         (pace == PACE_RECV_LAGS ? 12 : pace == PACE_SEND_LAGS ? 74 : 0))
                    in_valid <= 1'b0;
                else if (row_idx < dir_rows.size())
                begin
                    cur_req  <= dir_rows[row_idx];
                    in_valid <= 1'b1;
                    row_idx++;
                end
                else
                begin
                    cur_req  <= make_random_request();
                    in_valid <= 1'b1;
                    rand_made++;
                end
            end
        end
    end

    // Output side. On entering the open phase the receiver holds off for a
    // long stretch while the sender keeps offering, so the pipeline backs
    // up into in_stall; otherwise it stalls at the phase's rate.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pace == PACE_OPEN && squeeze_left != 0)
            begin
                out_stall    <= 1'b1;
                squeeze_left <= squeeze_left - 1;
            end
            else
                out_stall <= ($urandom_range(99, 0) <
                              (pace == PACE_RECV_LAGS ? 74 : pace == PACE_SEND_LAGS ? 12 : 0));
        end
    end

    // Watchdog: no beat on either channel for too long means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else if (stuck_cycles == STUCK_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            else
                stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        // Directed table. Rows with a typed outcome are the obvious ones:
        // empty queue, first push, full queue, misses.
        // empty queue: pop, query and cancel all miss, both flags set
        add_row(KIND_POP,    16'h0000, 1'b0, 32'h0, 1'b1, 1'b1, 1'b1, plain(0, 0, 1, 1));
        add_row(KIND_QUERY,  16'h0000, 1'b0, 32'h0, 1'b0, 1'b0, 1'b1, plain(0, 0, 1, 1));
        add_row(KIND_CANCEL, 16'hFFFF, 1'b0, 32'h0, 1'b0, 1'b0, 1'b1, plain(0, 0, 1, 1));
        // extreme tags and payloads, then a duplicate tag going the other way
        add_row(KIND_PUSH, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b1, plain(1, 0, 0, 1));
        add_row(KIND_PUSH, 16'h0000, 1'b0, 32'h0000_0000, 1'b0, 1'b0, 1'b1, plain(1, 0, 0, 0));
        add_row(KIND_PUSH, 16'hFFFF, 1'b0, 32'h5A5A_5A5A, 1'b0, 1'b0, 1'b1, plain(1, 0, 0, 0));
        // fill to DEPTH with alternating directions
        for (int i = 0; i < DEPTH - 3; i++)
            add_row(KIND_PUSH, TAG_W'(16'h0100 + i), i[0], 32'hC0DE_0000 | i,
                    1'b0, 1'b0, 1'b0, '0);
        // full queue: push refused, absent tag reports the whole count
        add_row(KIND_PUSH,  16'h0BAD, 1'b1, 32'h1234_5678, 1'b1, 1'b1, 1'b1, plain(0, 0, 0, 0));
        add_row(KIND_QUERY, 16'h0BAD, 1'b0, 32'h0, 1'b0, 1'b0, 1'b1, plain(0, DEPTH, 0, 0));
        // duplicate tag: query sees the oldest copy
        add_row(KIND_QUERY, 16'hFFFF, 1'b0, 32'h0, 1'b0, 1'b0, 1'b1, plain(1, 0, 0, 0));
        // pop with neither direction enabled leaves everything alone
        add_row(KIND_POP,   16'h0000, 1'b0, 32'h0, 1'b0, 1'b0, 1'b1, plain(0, 0, 0, 0));
        add_row(KIND_POP,   16'h0000, 1'b0, 32'h0, 1'b0, 1'b1, 1'b0, '0);
        add_row(KIND_POP,   16'h0000, 1'b0, 32'h0, 1'b1, 1'b0, 1'b0, '0);
        // cancel the remaining copy, then miss on it
        add_row(KIND_CANCEL, 16'hFFFF, 1'b0, 32'h0, 1'b0, 1'b0, 1'b0, '0);
        add_row(KIND_CANCEL, 16'hFFFF, 1'b0, 32'h0, 1'b0, 1'b0, 1'b1, plain(0, 0, 0, 0));
        // both directions enabled: plain oldest-first
        add_row(KIND_POP,   16'h0000, 1'b0, 32'h0, 1'b1, 1'b1, 1'b0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (!(stim_done && due_results.size() == 0))
            @(posedge clk);
        // catch any stray beat after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/dfrq_pkg.sv
rtl/dfrq_cell.sv
rtl/direction_filtered_request_queue_top.sv
tb/direction_filtered_request_queue_top_tb.sv
